>>> rtl/rrqs_pkg.sv
// shared types and constants for the round-robin quantum scheduler
`default_nettype none

package rrqs_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int OCC_W      = $clog2(RING_DEPTH + 1);

  localparam logic [7:0] QUANTUM_RESET = 8'd5;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  localparam logic [2:0] ST_RAN    = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_ACCEPT = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_LATE   = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [15:0] job_tag;
    logic [31:0] arrival_time;
    logic [15:0] job_length;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_tag;
    logic [7:0]  time_used;
    logic [31:0] tick_count;
  } result_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] remain;
  } ring_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_sts_t;

endpackage

`default_nettype wire

>>> rtl/round_robin_quantum_scheduler.sv
// top level of the single-cpu round-robin scheduler with a writable quantum
`default_nettype none

// usage
//   request channel (request_valid / request_stall / request): one item is either
//   a job arrival or a scheduling tick; each item gives exactly one result on the
//   result channel (result_valid / result_stall / result)
//   quantum channel (quantum_valid / quantum_ready / quantum_value) writes the
//   quantum register; write it only while no request is in flight
// timing
//   an arrival or a tick on an empty ring is answered from the idle state; a tick
//   that runs a job pops the head entry of the ring memory in the idle state
//   (registered read), then computes the run and writes the job back to the tail in
//   the read state (separate read and write ports); results go to the output register
// stalls
//   the output register holds a result while result_stall is high; the block still
//   takes the next request, and parks its result in a hold register; request_stall
//   is high while that one is full and while a tick runs a job in the read state
// reset
//   rst (synchronous) empties the ring, zeroes time and tick count and sets the
//   quantum to 5; no clearing pass is needed since the ring is never read empty
module round_robin_quantum_scheduler (
  input  wire                clk,
  input  wire                rst,
  input  wire                request_valid,
  output logic               request_stall,
  input  rrqs_pkg::request_t request,
  output logic               result_valid,
  input  wire                result_stall,
  output rrqs_pkg::result_t  result,
  input  wire                quantum_valid,
  output logic               quantum_ready,
  input  wire  [7:0]         quantum_value
);
  import rrqs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} state_t;

  state_t      state;
  logic [7:0]  quantum;
  logic [31:0] now_time;
  logic [31:0] ticks_done;
  result_t     pend;

  ring_ctl_t   ring_ctl;
  ring_sts_t   ring_sts;
  ring_entry_t wr_entry;
  ring_entry_t rd_entry;

  logic        acc;
  logic        out_free;
  logic        out_load;
  logic        is_tick;
  logic        late;
  result_t     res_next;
  logic [7:0]  used;
  logic [15:0] rem;

  // new requests only between items; results may still sit in the output register
  assign request_stall = (state != S_IDLE);
  assign quantum_ready = (state == S_IDLE);
  assign acc           = request_valid && !request_stall;
  assign out_free      = !result_valid || !result_stall;
  assign is_tick       = (request.kind == KIND_TICK);
  assign late          = (request.arrival_time != now_time);

  // a result goes into the output register this cycle
  assign out_load = out_free &&
                    ((state == S_IDLE && acc && !(is_tick && !ring_sts.empty)) ||
                     state == S_READ || state == S_HOLD);

  // run length of the head job: the smaller of remaining time and quantum
  assign used = (rd_entry.remain < {8'd0, quantum}) ? rd_entry.remain[7:0] : quantum;
  assign rem  = rd_entry.remain - {8'd0, used};

  always_comb begin
    ring_ctl = '0;
    wr_entry = '0;
    res_next = '0;
    unique case (state)
      S_IDLE: begin
        if (is_tick) begin
          // idle tick; a tick with work reports from the read state
          ring_ctl.pop        = acc && !ring_sts.empty;
          res_next.status     = ST_IDLE;
          res_next.tick_count = ticks_done + 32'd1;
        end else begin
          res_next.tick_count = ticks_done;
          wr_entry.tag        = request.job_tag;
          wr_entry.remain     = request.job_length;
          if (late) begin
            res_next.status = ST_LATE;
          end else if (ring_sts.full) begin
            res_next.status = ST_FULL;
          end else begin
            ring_ctl.push       = acc;
            res_next.status     = ST_ACCEPT;
            res_next.served_tag = request.job_tag;
          end
        end
      end
      S_READ: begin
        // requeue an unfinished job at the tail
        ring_ctl.push       = (rem != 16'd0);
        wr_entry.tag        = rd_entry.tag;
        wr_entry.remain     = rem;
        res_next.status     = (rem == 16'd0) ? ST_DONE : ST_RAN;
        res_next.served_tag = rd_entry.tag;
        res_next.time_used  = used;
        res_next.tick_count = ticks_done;
      end
      S_HOLD: begin
        res_next = pend;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  rrqs_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry),
    .sts      (ring_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      quantum      <= QUANTUM_RESET;
      now_time     <= '0;
      ticks_done   <= '0;
      result_valid <= 1'b0;
    end else begin
      // load a new result, or drop one the receiver has taken
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (quantum_valid && quantum_ready) begin
        quantum <= quantum_value;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_tick) begin
              now_time   <= now_time + {24'd0, quantum};
              ticks_done <= ticks_done + 32'd1;
            end
            if (is_tick && !ring_sts.empty) begin
              state <= S_READ;
            end else if (out_free) begin
              result <= res_next;
            end else begin
              pend  <= res_next;
              state <= S_HOLD;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            result <= res_next;
            state  <= S_IDLE;
          end else begin
            pend  <= res_next;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            result <= pend;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ring never overflows or underflows
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ring_ctl.push |-> !ring_sts.full)
    else $error("push into full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ring_ctl.pop |-> !ring_sts.empty)
    else $error("pop from empty ring");

  // a tick with work goes to the read state next
  a_tick_reads: assert property (@(posedge clk) disable iff (rst)
    ring_ctl.pop |=> state == S_READ)
    else $error("pop without read cycle");

  // arrivals and idle ticks never report run time
  a_arrival_no_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_ACCEPT || result.status == ST_FULL ||
                     result.status == ST_LATE || result.status == ST_IDLE)
      |-> result.time_used == 8'd0)
    else $error("nonzero time on arrival or idle result");

  // a held result always has the output register still busy
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> result_valid)
    else $error("hold state with free output register");

endmodule

`default_nettype wire

>>> rtl/rrqs_ring.sv
// ready ring: job memory with head, tail and occupancy
`default_nettype none

module rrqs_ring (
  input  wire                  clk,
  input  wire                  rst,
  input  rrqs_pkg::ring_ctl_t   ctl,
  input  rrqs_pkg::ring_entry_t wr_entry,
  output rrqs_pkg::ring_entry_t rd_entry,
  output rrqs_pkg::ring_sts_t   sts
);
  import rrqs_pkg::*;

  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

  ring_entry_t mem [RING_DEPTH];

  logic [RING_AW-1:0] head;
  logic [RING_AW-1:0] tail;
  logic [OCC_W-1:0]   occupancy;

  assign sts.empty = (occupancy == '0);
  assign sts.full  = (occupancy == OCC_W'(RING_DEPTH));

  // storage, no reset; entries are only read while the ring holds them
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_entry;
    end
    if (ctl.pop) begin
      rd_entry <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
    end else begin
      if (ctl.push) begin
        tail <= (tail == RING_LAST) ? '0 : tail + RING_AW'(1);
      end
      if (ctl.pop) begin
        head <= (head == RING_LAST) ? '0 : head + RING_AW'(1);
      end
      if (ctl.push && !ctl.pop) begin
        occupancy <= occupancy + OCC_W'(1);
      end else if (ctl.pop && !ctl.push) begin
        occupancy <= occupancy - OCC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/schedule_checker.sv
// checker for the round-robin quantum scheduler: watches the channels, predicts and compares
`default_nettype none

module schedule_checker
  import rrqs_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        request_valid,
  input  wire        request_stall,
  input  request_t   request,
  input  wire        result_valid,
  input  wire        result_stall,
  input  result_t    result,
  input  wire        quantum_valid,
  input  wire        quantum_ready,
  input  wire  [7:0] quantum_value,
  output int         fails,
  output int         pending
);

  // shadow copy of the scheduler state
  ring_entry_t          ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]   head_idx;
  logic [RING_AW-1:0]   tail_idx;
  logic [OCC_W-1:0]     occ;
  logic [31:0]          clock_now;
  logic [31:0]          ticks;
  logic [7:0]           quantum_q;

  result_t due_results [$];

  function automatic logic [RING_AW-1:0] bump(logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic void enqueue_job(logic [15:0] tag, logic [15:0] remain);
    ring_mem[tail_idx] = '{tag: tag, remain: remain};
    tail_idx = bump(tail_idx);
    occ = occ + 1'b1;
  endfunction

  // expected result of one request, advancing the shadow state
  function automatic result_t schedule_step(request_t r);
    result_t     res;
    ring_entry_t job;
    logic [15:0] slice;
    res = '0;
    if (r.kind == KIND_ARRIVAL) begin
      if (r.arrival_time != clock_now) begin
        res.status = ST_LATE;
      end else if (occ >= RING_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_ACCEPT;
        res.served_tag = r.job_tag;
        enqueue_job(r.job_tag, r.job_length);
      end
    end else begin
      if (occ == 0) begin
        res.status = ST_IDLE;
      end else begin
        job = ring_mem[head_idx];
        head_idx = bump(head_idx);
        occ = occ - 1'b1;
        res.served_tag = job.tag;
        slice = (job.remain < {8'd0, quantum_q}) ? job.remain : {8'd0, quantum_q};
        res.time_used = slice[7:0];
        job.remain = job.remain - slice;
        if (job.remain == 0) begin
          res.status = ST_DONE;
        end else begin
          res.status = ST_RAN;
          enqueue_job(job.tag, job.remain);
        end
      end
      clock_now = clock_now + {24'd0, quantum_q};
      ticks = ticks + 1;
    end
    res.tick_count = ticks;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      head_idx = '0;
      tail_idx = '0;
      occ = '0;
      clock_now = '0;
      ticks = '0;
      quantum_q = QUANTUM_RESET;
      due_results.delete();
    end else begin
      if (quantum_valid && quantum_ready) begin
        quantum_q = quantum_value;
      end
      if (request_valid && !request_stall) begin
        due_results.push_back(schedule_step(request));
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("served_tag", 32'(want.served_tag), 32'(got.served_tag));
          check_field("time_used", 32'(want.time_used), 32'(got.time_used));
          check_field("tick_count", want.tick_count, got.tick_count);
        end
      end
    end
    pending = due_results.size();
  end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench top for the round-robin quantum scheduler: request stimulus, stalls and verdict
`default_nettype none

module tb;
  import rrqs_pkg::*;

  // generous bound, several times the slowest legal run
  localparam int LIMIT = 1_000_000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       request_valid = 1'b0;
  logic       request_stall;
  request_t   request = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       quantum_valid = 1'b0;
  logic       quantum_ready;
  logic [7:0] quantum_value = '0;

  int fails;
  int pending;
  int cycle_count = 0;
  int stall_left = 0;

  // stimulus-side view of the block's clock and quantum, used to time arrivals
  logic [31:0] now_est = '0;
  logic [7:0]  q_est = QUANTUM_RESET;
  // when set the sender runs back to back with no gaps
  bit          calm = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  round_robin_quantum_scheduler u_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .quantum_valid (quantum_valid),
    .quantum_ready (quantum_ready),
    .quantum_value (quantum_value)
  );

  schedule_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .quantum_valid (quantum_valid),
    .quantum_ready (quantum_ready),
    .quantum_value (quantum_value),
    .fails         (fails),
    .pending       (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL round_robin_quantum_scheduler");
      $finish;
    end
  end

  // receiver stalls: quiet stretches, mostly short stalls, now and then a long one
  always @(negedge clk) begin
    int r;
    if (rst || (cycle_count / 1500) % 3 == 0) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b1;
        stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 50);
      end
    end
  end

  // sender gap before a request: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly short jobs; some zero-length, some long enough to circle the ring many times
  function automatic logic [15:0] job_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'd0;
    if (r < 8) return 16'($urandom);
    if (r < 12) return 16'($urandom_range(256, 2000));
    return 16'($urandom_range(1, 24));
  endfunction

  function automatic request_t arrival(logic [15:0] tag, logic [15:0] len, bit on_time);
    logic [31:0] at;
    if (on_time) begin
      at = now_est;
    end else begin
      // near misses and far misses
      case ($urandom_range(0, 2))
        0:       at = now_est + 1;
        1:       at = now_est - 1;
        default: at = $urandom;
      endcase
      if (at == now_est) at = ~now_est;
    end
    return '{kind: KIND_ARRIVAL, job_tag: tag, arrival_time: at, job_length: len};
  endfunction

  // tick with junk in the fields the block ignores
  function automatic request_t tick_req();
    return '{kind: KIND_TICK, job_tag: 16'($urandom), arrival_time: $urandom,
             job_length: 16'($urandom)};
  endfunction

  // one request on the request channel; valid stays high after acceptance so a
  // following request can go out back to back, callers lower it before pausing
  task automatic send(request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      request_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request = r;
    request_valid = 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    // a tick moves the block's clock by the quantum in force
    if (r.kind == KIND_TICK) now_est = now_est + {24'd0, q_est};
    @(negedge clk);
  endtask

  // hold the sender until every predicted result has come back
  task automatic wait_idle();
    request_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // quantum write, only issued with the block idle
  task automatic write_quantum(logic [7:0] v);
    quantum_value = v;
    quantum_valid = 1'b1;
    @(posedge clk);
    while (!quantum_ready) @(posedge clk);
    @(negedge clk);
    quantum_valid = 1'b0;
    q_est = v;
  endtask

  // mixed ticks and arrivals, mostly on time, with one full drain in the middle
  task automatic random_phase(int count, int tick_pct);
    int hold_at;
    hold_at = $urandom_range(count / 4, 3 * count / 4);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == hold_at) wait_idle();
      if ($urandom_range(0, 99) < tick_pct) begin
        send(tick_req());
      end else begin
        send(arrival(16'($urandom), job_len(), $urandom_range(0, 99) < 85));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset quantum, idle tick, misses, zero-length and extreme jobs
    send(tick_req());                               // empty ring reports idle
    send(arrival(16'h0001, 16'd4, 1'b0));           // wrong time
    send('{kind: KIND_ARRIVAL, job_tag: 16'h5a5a, arrival_time: 32'hffff_ffff,
           job_length: 16'h0001});                  // wrong time, all ones
    send(arrival(16'hffff, 16'd7, 1'b1));           // needs more than one quantum
    send(arrival(16'h0000, 16'd0, 1'b1));           // zero-length job
    send(arrival(16'h1234, 16'd3, 1'b1));           // finishes inside one quantum
    send(arrival(16'ha5a5, 16'hffff, 1'b1));        // longest job
    send('{kind: KIND_ARRIVAL, job_tag: 16'h0002, arrival_time: 32'h0,
           job_length: 16'd5});                     // stale time zero
    repeat (6) send(tick_req());
    send(arrival(16'h8001, 16'd5, 1'b1));           // exactly one quantum
    repeat (3) send(tick_req());
    send(arrival(16'h7ffe, 16'd1, 1'b1));
    send(tick_req());

    // settings sweep, extremes included; zero quantum makes no progress
    wait_idle();
    write_quantum(8'd1);
    random_phase(150, 50);
    wait_idle();
    write_quantum(8'd255);
    random_phase(150, 50);
    wait_idle();
    write_quantum(8'd0);
    random_phase(150, 50);
    wait_idle();
    write_quantum(8'($urandom_range(2, 254)));
    random_phase(150, 50);
    wait_idle();
    write_quantum(QUANTUM_RESET);
    random_phase(150, 55);

    // fill the ring to capacity and past it, with misses sprinkled in
    wait_idle();
    write_quantum(8'd255);
    for (int i = 0; i < 1060; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      if (i % 97 == 50) begin
        send(arrival(16'($urandom), 16'd9, 1'b0));
      end else begin
        send(arrival(16'($urandom), 16'($urandom_range(1, 255)), 1'b1));
      end
    end
    calm = 1'b0;
    // around the full boundary: pops make room, arrivals take it again
    random_phase(40, 50);

    wait_idle();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("PASS round_robin_quantum_scheduler");
    end else begin
      $display("FAIL round_robin_quantum_scheduler");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/rrqs_pkg.sv
rtl/rrqs_ring.sv
rtl/round_robin_quantum_scheduler.sv
tb/sv/schedule_checker.sv
tb/sv/tb.sv
